FILE: sv/sdsq_pkg.sv
// Package for the SPI-mode SD card sequencer: phase and resume codes, host
// commands, status and card kinds, frame constants. No dependencies.
package sdsq_pkg;

  localparam int unsigned BlockBytes = 512;

  typedef enum logic [4:0] {
    PH_IDLE, PH_DUMMY, PH_PRE_H, PH_PRE_L, PH_FRAME, PH_POLL, PH_R7, PH_OCR,
    PH_TOKEN, PH_DATA, PH_WHDR1, PH_WHDR2, PH_WBYTE, PH_FILL, PH_DRESP,
    PH_BUSY, PH_RELEASE
  } phase_e;

  typedef enum logic [2:0] {
    RS_CMD0, RS_CMD8, RS_PROBE, RS_IDLE, RS_CMD58, RS_CMD16, RS_CMD17, RS_CMD24
  } resume_e;

  typedef enum logic [2:0] {
    CMD_XFER_DONE = 3'd0, CMD_INIT = 3'd1, CMD_READ = 3'd2, CMD_WR_BEGIN = 3'd3,
    CMD_WR_BYTE = 3'd4, CMD_WR_END = 3'd5, CMD_RSVD6 = 3'd6, CMD_RSVD7 = 3'd7
  } command_e;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StErr    = 2'd1;
  localparam logic [1:0] StNoInit = 2'd2;

  localparam logic [2:0] KindNone     = 3'd0;
  localparam logic [2:0] KindMmc      = 3'd1;
  localparam logic [2:0] KindSdv1     = 3'd2;
  localparam logic [2:0] KindSdv2Byte = 3'd3;
  localparam logic [2:0] KindSdv2Blk  = 3'd4;

  localparam logic [7:0] OpGoIdle   = 8'h40;
  localparam logic [7:0] OpOpCond   = 8'h41;
  localparam logic [7:0] OpAppCond  = 8'hE9;
  localparam logic [7:0] OpIfCond   = 8'h48;
  localparam logic [7:0] OpBlockLen = 8'h50;
  localparam logic [7:0] OpReadOne  = 8'h51;
  localparam logic [7:0] OpWriteOne = 8'h58;
  localparam logic [7:0] OpAppPref  = 8'h77;
  localparam logic [7:0] OpReadOcr  = 8'h7A;

  localparam logic [1:0] CfgRespPoll  = 2'd0;
  localparam logic [1:0] CfgIdleRetry = 2'd1;
  localparam logic [1:0] CfgTokenPoll = 2'd2;
  localparam logic [1:0] CfgBusyPoll  = 2'd3;

  typedef struct packed {
    logic [7:0]  resp_poll;
    logic [15:0] idle_retry;
    logic [15:0] token_poll;
    logic [15:0] busy_poll;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  rx_byte;
    logic [31:0] sector;
    logic [8:0]  offset;
    logic [9:0]  count;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_card;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       done_res;
    logic [1:0] status;
    logic [2:0] card_kind;
  } result_t;

  function automatic logic [47:0] make_frame(logic [7:0] op, logic [31:0] arg);
    logic [7:0] crc;
    crc = 8'h01;
    if (op == OpGoIdle) crc = 8'h95;
    if (op == OpIfCond) crc = 8'h87;
    return {op, arg, crc};
  endfunction

endpackage

FILE: sv/sdsq_cfg_regs.sv
// Configuration registers for the SD card sequencer: poll and retry limits.
// Depends on sdsq_pkg.
module sdsq_cfg_regs import sdsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        cfg_ready_o,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.resp_poll  <= 8'd10;
      cfg_q.idle_retry <= 16'd1000;
      cfg_q.token_poll <= 16'd1000;
      cfg_q.busy_poll  <= 16'd10000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgRespPoll:  cfg_q.resp_poll  <= cfg_data_i[7:0];
        CfgIdleRetry: cfg_q.idle_retry <= cfg_data_i;
        CfgTokenPoll: cfg_q.token_poll <= cfg_data_i;
        CfgBusyPoll:  cfg_q.busy_poll  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/sdsq_core.sv
// Sequencer core: the registered state and one-pass next-state logic for one
// exchange item. Depends on sdsq_pkg.
module sdsq_core import sdsq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  phase_e      phase_q, phase_d;
  resume_e     resume_q, resume_d;
  logic [2:0]  card_type_q, card_type_d;
  logic [47:0] frame_q, frame_d;
  logic [6:0]  pend_cmd_q, pend_cmd_d;
  logic [31:0] pend_arg_q, pend_arg_d;
  logic [15:0] retry_q, retry_d;
  logic [9:0]  bcnt_q, bcnt_d;
  logic [31:0] resp_q, resp_d;
  logic [9:0]  wleft_q, wleft_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  idle_cmd_q, idle_cmd_d;
  logic        idle_arg_q, idle_arg_d;
  logic [8:0]  rfirst_q, rfirst_d;
  logic [9:0]  rend_q, rend_d;
  logic [1:0]  fstat_q, fstat_d;
  logic        cs_q, cs_d;

  logic [10:0] end_sum;
  logic [31:0] addr;
  logic [7:0]  rx;
  logic [31:0] resp_sh;

  assign rx = item_i.rx_byte;
  assign end_sum = {2'b0, item_i.offset} + {1'b0, item_i.count};
  assign addr = (card_type_q == KindSdv2Blk) ? item_i.sector : {item_i.sector[22:0], 9'd0};
  assign resp_sh = {resp_q[23:0], rx};

  always_comb begin
    logic [7:0] sc_op;
    logic [31:0] sc_arg;
    logic sc_go;
    logic [1:0] rel_st;
    logic rel_go;
    logic [2:0] ie_ty;
    logic ie_go;
    logic ia_go;
    logic ac_go;
    logic [7:0] ac_r;
    logic [15:0] ia_retry;
    sc_op = 8'd0; sc_arg = 32'd0; sc_go = 1'b0;
    rel_st = StOk; rel_go = 1'b0;
    ie_ty = KindNone; ie_go = 1'b0;
    ia_go = 1'b0; ac_go = 1'b0; ac_r = rx; ia_retry = retry_q;
    phase_d = phase_q; resume_d = resume_q; card_type_d = card_type_q;
    frame_d = frame_q; pend_cmd_d = pend_cmd_q; pend_arg_d = pend_arg_q;
    retry_d = retry_q; bcnt_d = bcnt_q; resp_d = resp_q; wleft_d = wleft_q;
    kind_d = kind_q; idle_cmd_d = idle_cmd_q; idle_arg_d = idle_arg_q;
    rfirst_d = rfirst_q; rend_d = rend_q; fstat_d = fstat_q; cs_d = cs_q;
    res_o = '0;

    unique case (command_e'(item_i.command))
      CMD_XFER_DONE: begin
        unique case (phase_q)
          PH_DUMMY: begin
            if (bcnt_q != 10'd0) begin
              bcnt_d = bcnt_q - 10'd1;
              res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b0;
            end else begin
              sc_go = 1'b1; sc_op = OpGoIdle; sc_arg = '0; resume_d = RS_CMD0;
            end
          end
          PH_PRE_H: begin
            phase_d = PH_PRE_L;
            res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
          end
          PH_PRE_L, PH_FRAME: begin
            if (phase_q == PH_PRE_L || bcnt_q < 10'd6) begin
              phase_d = PH_FRAME;
              res_o.tx_valid = 1'b1; res_o.tx_byte = frame_q[47:40]; cs_d = 1'b1;
              frame_d = {frame_q[39:0], 8'd0};
              bcnt_d = (phase_q == PH_PRE_L) ? 10'd1 : bcnt_q + 10'd1;
            end else begin
              bcnt_d = (cfg_i.resp_poll != 8'd0) ? {2'b0, cfg_i.resp_poll} : 10'd256;
              phase_d = PH_POLL;
              res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
            end
          end
          PH_POLL: begin
            if (rx[7] && bcnt_q != 10'd1) begin
              bcnt_d = bcnt_q - 10'd1;
              res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
            end else begin
              if (rx[7]) bcnt_d = 10'd0;
              pend_cmd_d = 7'd0;
              if (pend_cmd_q != 7'd0 && rx <= 8'd1) begin
                frame_d = make_frame({1'b0, pend_cmd_q}, pend_arg_q);
                phase_d = PH_PRE_H;
                res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b0;
              end else begin
                ac_go = 1'b1;
              end
            end
          end
          PH_R7, PH_OCR: begin
            resp_d = resp_sh;
            bcnt_d = bcnt_q + 10'd1;
            if (bcnt_q < 10'd3) begin
              res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
            end else if (phase_q == PH_OCR) begin
              ie_go = 1'b1; ie_ty = resp_sh[30] ? KindSdv2Blk : KindSdv2Byte;
            end else if (resp_sh[15:0] == 16'h01AA) begin
              kind_d = KindSdv2Byte; idle_cmd_d = OpAppCond; idle_arg_d = 1'b1;
              ia_retry = cfg_i.idle_retry; retry_d = cfg_i.idle_retry; ia_go = 1'b1;
            end else begin
              ie_go = 1'b1; ie_ty = KindNone;
            end
          end
          PH_TOKEN: begin
            if (rx == 8'hFF) begin
              retry_d = retry_q - 16'd1;
              if (retry_q != 16'd1) begin
                res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
              end else begin
                rel_go = 1'b1; rel_st = StErr;
              end
            end else if (rx == 8'hFE) begin
              bcnt_d = 10'd0; phase_d = PH_DATA;
              res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
            end else begin
              rel_go = 1'b1; rel_st = StErr;
            end
          end
          PH_DATA: begin
            if (bcnt_q >= {1'b0, rfirst_q} && bcnt_q < rend_q) begin
              res_o.rd_valid = 1'b1; res_o.rd_byte = rx;
            end
            bcnt_d = bcnt_q + 10'd1;
            if (bcnt_q < 10'(BlockBytes + 1)) begin
              res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
            end else begin
              rel_go = 1'b1; rel_st = StOk;
            end
          end
          PH_WHDR1: begin
            phase_d = PH_WHDR2;
            res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFE; cs_d = 1'b1;
          end
          PH_WHDR2: begin
            wleft_d = 10'(BlockBytes);
            phase_d = PH_IDLE; res_o.done_res = 1'b1; res_o.status = StOk;
          end
          PH_WBYTE: begin
            phase_d = PH_IDLE; res_o.done_res = 1'b1; res_o.status = StOk;
          end
          PH_FILL: begin
            res_o.tx_valid = 1'b1;
            if (bcnt_q != 10'd0) begin
              bcnt_d = bcnt_q - 10'd1; res_o.tx_byte = 8'h00;
            end else begin
              phase_d = PH_DRESP; res_o.tx_byte = 8'hFF;
            end
          end
          PH_DRESP: begin
            if (rx[4:0] == 5'h05) begin
              retry_d = cfg_i.busy_poll; phase_d = PH_BUSY;
              res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF;
            end else begin
              rel_go = 1'b1; rel_st = StErr;
            end
          end
          PH_BUSY: begin
            if (rx == 8'hFF) begin
              rel_go = 1'b1; rel_st = (retry_q != 16'd0) ? StOk : StErr;
            end else if (retry_q == 16'd0) begin
              rel_go = 1'b1; rel_st = StErr;
            end else begin
              retry_d = retry_q - 16'd1;
              res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF;
            end
          end
          PH_RELEASE: begin
            phase_d = PH_IDLE; res_o.done_res = 1'b1; res_o.status = fstat_q;
          end
          default: ;
        endcase
      end
      CMD_INIT: begin
        pend_cmd_d = 7'd0; bcnt_d = 10'd9; phase_d = PH_DUMMY;
        res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b0;
      end
      CMD_READ: begin
        rfirst_d = item_i.offset;
        rend_d = (end_sum > 11'(BlockBytes)) ? 10'(BlockBytes) : end_sum[9:0];
        sc_go = 1'b1; sc_op = OpReadOne; sc_arg = addr; resume_d = RS_CMD17;
      end
      CMD_WR_BEGIN: begin
        sc_go = 1'b1; sc_op = OpWriteOne; sc_arg = addr; resume_d = RS_CMD24;
      end
      CMD_WR_BYTE: begin
        if (wleft_q != 10'd0) begin
          wleft_d = wleft_q - 10'd1; phase_d = PH_WBYTE;
          res_o.tx_valid = 1'b1; res_o.tx_byte = item_i.write_byte;
        end else begin
          phase_d = PH_IDLE; res_o.done_res = 1'b1; res_o.status = StOk;
        end
      end
      CMD_WR_END: begin
        bcnt_d = wleft_q + 10'd1; wleft_d = 10'd0; phase_d = PH_FILL;
        res_o.tx_valid = 1'b1; res_o.tx_byte = 8'h00;
      end
      default: ;
    endcase

    // Resume after a command response.
    if (ac_go) begin
      unique case (resume_q)
        RS_CMD0: begin
          if (ac_r == 8'd1) begin
            sc_go = 1'b1; sc_op = OpIfCond; sc_arg = 32'h1AA; resume_d = RS_CMD8;
          end else begin
            ie_go = 1'b1; ie_ty = KindNone;
          end
        end
        RS_CMD8: begin
          if (ac_r == 8'd1) begin
            bcnt_d = 10'd0; resp_d = 32'd0; phase_d = PH_R7;
            res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
          end else begin
            sc_go = 1'b1; sc_op = OpAppCond; sc_arg = 32'd0; resume_d = RS_PROBE;
          end
        end
        RS_PROBE: begin
          if (ac_r <= 8'd1) begin
            kind_d = KindSdv1; idle_cmd_d = OpAppCond;
          end else begin
            kind_d = KindMmc; idle_cmd_d = OpOpCond;
          end
          idle_arg_d = 1'b0;
          retry_d = cfg_i.idle_retry; ia_retry = cfg_i.idle_retry; ia_go = 1'b1;
        end
        RS_IDLE: begin
          if (ac_r == 8'd0) begin
            sc_go = 1'b1;
            if (kind_q == KindSdv2Byte) begin
              sc_op = OpReadOcr; sc_arg = 32'd0; resume_d = RS_CMD58;
            end else begin
              sc_op = OpBlockLen; sc_arg = 32'(BlockBytes); resume_d = RS_CMD16;
            end
          end else begin
            retry_d = retry_q - 16'd1; ia_retry = retry_q - 16'd1; ia_go = 1'b1;
          end
        end
        RS_CMD58: begin
          if (ac_r == 8'd0) begin
            bcnt_d = 10'd0; resp_d = 32'd0; phase_d = PH_OCR;
            res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
          end else begin
            ie_go = 1'b1; ie_ty = KindNone;
          end
        end
        RS_CMD16: begin
          ie_go = 1'b1; ie_ty = (ac_r == 8'd0) ? kind_q : KindNone;
        end
        RS_CMD17: begin
          if (ac_r == 8'd0) begin
            retry_d = cfg_i.token_poll; phase_d = PH_TOKEN;
            res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
          end else begin
            rel_go = 1'b1; rel_st = StErr;
          end
        end
        RS_CMD24: begin
          if (ac_r == 8'd0) begin
            phase_d = PH_WHDR1;
            res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b1;
          end else begin
            wleft_d = 10'd0; phase_d = PH_IDLE;
            res_o.done_res = 1'b1; res_o.status = StErr;
          end
        end
        default: ;
      endcase
    end

    // Next idle-exit attempt, or give up.
    if (ia_go) begin
      if (ia_retry == 16'd0) begin
        ie_go = 1'b1; ie_ty = KindNone;
      end else begin
        sc_go = 1'b1; sc_op = idle_cmd_d; resume_d = RS_IDLE;
        sc_arg = {1'b0, idle_arg_d, 30'd0};
      end
    end

    if (ie_go) begin
      card_type_d = ie_ty;
      rel_go = 1'b1; rel_st = (ie_ty != KindNone) ? StOk : StNoInit;
    end

    if (rel_go) begin
      fstat_d = rel_st; phase_d = PH_RELEASE;
      res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b0;
    end

    if (sc_go) begin
      if (sc_op[7]) begin
        pend_cmd_d = sc_op[6:0]; pend_arg_d = sc_arg;
        frame_d = make_frame(OpAppPref, 32'd0);
      end else begin
        pend_cmd_d = 7'd0;
        frame_d = make_frame(sc_op, sc_arg);
      end
      phase_d = PH_PRE_H;
      res_o.tx_valid = 1'b1; res_o.tx_byte = 8'hFF; cs_d = 1'b0;
    end

    res_o.select_card = cs_d;
    res_o.card_kind = card_type_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; resume_q <= RS_CMD0; card_type_q <= KindNone;
      frame_q <= '0; pend_cmd_q <= '0; pend_arg_q <= '0; retry_q <= '0;
      bcnt_q <= '0; resp_q <= '0; wleft_q <= '0; kind_q <= KindNone;
      idle_cmd_q <= '0; idle_arg_q <= 1'b0; rfirst_q <= '0; rend_q <= '0;
      fstat_q <= StOk; cs_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d; resume_q <= resume_d; card_type_q <= card_type_d;
      frame_q <= frame_d; pend_cmd_q <= pend_cmd_d; pend_arg_q <= pend_arg_d;
      retry_q <= retry_d; bcnt_q <= bcnt_d; resp_q <= resp_d; wleft_q <= wleft_d;
      kind_q <= kind_d; idle_cmd_q <= idle_cmd_d; idle_arg_q <= idle_arg_d;
      rfirst_q <= rfirst_d; rend_q <= rend_d; fstat_q <= fstat_d; cs_q <= cs_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |-> !res_o.tx_valid)
    else $error("done and exchange in one item");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done_res |=> phase_q == PH_IDLE)
    else $error("phase not idle after done");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.rd_valid |-> phase_q == PH_DATA)
    else $error("read byte outside data phase");

endmodule

FILE: sv/sd_spi_card_sequencer_unit.sv
// Top level of the SPI-mode SD card sequencer: input register, core and
// result register. Depends on sdsq_pkg, sdsq_cfg_regs and sdsq_core.
//
//  channel | handshake                 | payload
//  in      | in_valid_i / in_stall_o   | command, rx_byte, sector, offset, count, write_byte
//  out     | out_valid_o / out_stall_i | tx_valid .. card_kind
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each item is one SPI byte exchange, so the host sets the pace; an item can be
// taken every cycle while the result is not stalled. An accepted item passes
// through the input register and the core into the result register, where it
// waits while out_stall_i is high. Reset restores the default limits and an
// idle, deselected sequencer. A stalled result holds the input register, and
// the input stalls only while both registers are full and the result is stalled.
module sd_spi_card_sequencer_unit import sdsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] sector_i,
  input  logic [8:0]  offset_i,
  input  logic [9:0]  count_i,
  input  logic [7:0]  write_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        select_card_o,
  output logic        rd_valid_o,
  output logic [7:0]  rd_byte_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [2:0]  card_kind_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q, out_vld_q, step;
  result_t res, res_q;

  sdsq_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .cfg_ready_o, .cfg_o(cfg)
  );

  assign step = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;

  sdsq_core u_core (
    .clk_i, .rst_ni, .step_i(step), .item_i(item_q), .cfg_i(cfg), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (step) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= '{command: command_i, rx_byte: rx_byte_i, sector: sector_i,
                  offset: offset_i, count: count_i, write_byte: write_byte_i};
    end
    if (step) res_q <= res;
  end

  assign out_valid_o   = out_vld_q;
  assign tx_valid_o    = res_q.tx_valid;
  assign tx_byte_o     = res_q.tx_byte;
  assign select_card_o = res_q.select_card;
  assign rd_valid_o    = res_q.rd_valid;
  assign rd_byte_o     = res_q.rd_byte;
  assign done_res_o    = res_q.done_res;
  assign status_o      = res_q.status;
  assign card_kind_o   = res_q.card_kind;

endmodule
